[sv/lrupr_pkg.sv]
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared types and fixed constants of the LRU page replacement core.
// ----------------------------------------------------------------------------
package lrupr_pkg;

    // Fixed field widths of the ports.
    localparam int PAGE_IN_W = 16;
    localparam int CFG_W     = 5;
    localparam int WAY_OUT_W = 4;
    localparam int TOTAL_W   = 32;

    // Reset value of the active way count.
    localparam logic [CFG_W-1:0] WAYS_IN_USE_RESET = 5'd16;

    // Saturation value of the request and fault totals.
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // register the lookup of the accepted request
        logic commit;   // write the replacement state and the result
    } lrupr_cmd_t;

endpackage

[sv/lru_page_replacement_core.sv]
// ----------------------------------------------------------------------------
// lru_page_replacement_core
// Fully associative page cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Latency: a request accepted at one edge is looked up that cycle, updated in
// the next, and its result strobes on done in the cycle after the update.
// A new request is taken only once the update of the register way store is
// over (busy is high during the update); results cannot be stalled.
// Reset: all ways invalid, ranks and totals zero, 16 ways active, no clearing
// pass. A configuration write flushes the ways; totals are kept.
module lru_page_replacement_core
#(
    parameter int WAYS      = 16,
    parameter int PAGE_BITS = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [lrupr_pkg::PAGE_IN_W-1:0] page_number,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lrupr_pkg::CFG_W-1:0]     ways_in_use,
    output logic                            done,
    output logic                            hit,
    output logic [lrupr_pkg::WAY_OUT_W-1:0] way_used,
    output logic [lrupr_pkg::TOTAL_W-1:0]   request_total,
    output logic [lrupr_pkg::TOTAL_W-1:0]   fault_total
);

    lrupr_pkg::lrupr_cmd_t cmd;
    logic                  busy_int;

    lrupr_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy_int),
        .cmd   (cmd)
    );

    lrupr_datapath
    #(
        .WAYS      (WAYS),
        .PAGE_BITS (PAGE_BITS)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .page_number   (page_number),
        .cfg_write     (cfg_valid && cfg_ready),
        .ways_in_use   (ways_in_use),
        .done          (done),
        .hit           (hit),
        .way_used      (way_used),
        .request_total (request_total),
        .fault_total   (fault_total)
    );

    // Configuration beats are taken between updates and never in the same
    // cycle as a request beat.
    assign busy      = busy_int;
    assign cfg_ready = !busy_int && !start;

endmodule

[sv/lrupr_ctrl.sv]
// ----------------------------------------------------------------------------
// lrupr_ctrl
// Two-state sequencer: look up on accept, then update the store.
// ----------------------------------------------------------------------------
module lrupr_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    output lrupr_pkg::lrupr_cmd_t cmd
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_UPDATE = 1'b1;

    logic state_reg;
    logic state_next;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Commands and handshake status.
    assign busy        = (state_reg == ST_UPDATE);
    assign cmd.capture = start && (state_reg == ST_IDLE);
    assign cmd.commit  = (state_reg == ST_UPDATE);

endmodule

[sv/lrupr_datapath.sv]
// ----------------------------------------------------------------------------
// lrupr_datapath
// Way store, parallel tag compare, victim selection, rank update and totals.
// ----------------------------------------------------------------------------
module lrupr_datapath
#(
    parameter int WAYS      = 16,
    parameter int PAGE_BITS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  lrupr_pkg::lrupr_cmd_t               cmd,
    input  logic [lrupr_pkg::PAGE_IN_W-1:0]     page_number,
    input  logic                                cfg_write,
    input  logic [lrupr_pkg::CFG_W-1:0]         ways_in_use,
    output logic                                done,
    output logic                                hit,
    output logic [lrupr_pkg::WAY_OUT_W-1:0]     way_used,
    output logic [lrupr_pkg::TOTAL_W-1:0]       request_total,
    output logic [lrupr_pkg::TOTAL_W-1:0]       fault_total
);

    localparam int IDX_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = ($clog2(WAYS + 1) > lrupr_pkg::CFG_W) ?
                            $clog2(WAYS + 1) : lrupr_pkg::CFG_W;
    localparam int KEY_IN_W = (PAGE_BITS < lrupr_pkg::PAGE_IN_W) ?
                              PAGE_BITS : lrupr_pkg::PAGE_IN_W;
    localparam int OUT_W  = (IDX_W < lrupr_pkg::WAY_OUT_W) ? IDX_W : lrupr_pkg::WAY_OUT_W;
    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(WAYS - 1);
    localparam logic [CNT_W-1:0]  WAYS_CNT = CNT_W'(WAYS);

    // Lowest set position of a way vector.
    function automatic logic [IDX_W-1:0] first_set(input logic [WAYS-1:0] vec);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (vec[w])
            begin
                idx = IDX_W'(w);
            end
        end
        return idx;
    endfunction

    // Way store.
    logic [PAGE_BITS-1:0] page_reg [WAYS];
    logic [WAYS-1:0]      valid_reg;
    logic [RANK_W-1:0]    rank_reg [WAYS];
    logic [lrupr_pkg::CFG_W-1:0] ways_in_use_reg;

    // Lookup results held for the update cycle.
    logic [PAGE_BITS-1:0] key_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     way_reg;
    logic [RANK_W-1:0]    sel_rank_reg;

    // Totals and result registers.
    logic [lrupr_pkg::TOTAL_W-1:0] req_reg;
    logic [lrupr_pkg::TOTAL_W-1:0] flt_reg;
    logic [lrupr_pkg::TOTAL_W-1:0] req_next;
    logic [lrupr_pkg::TOTAL_W-1:0] flt_next;
    logic                          done_reg;
    logic                          hit_reg;
    logic [lrupr_pkg::WAY_OUT_W-1:0] way_used_reg;
    logic [lrupr_pkg::WAY_OUT_W-1:0] way_used_next;

    // Lookup signals.
    logic [PAGE_BITS-1:0] key_in;
    logic [CNT_W-1:0]     cnt_raw;
    logic [CNT_W-1:0]     cnt_eff;
    logic [CNT_W-1:0]     last_rank;
    logic [WAYS-1:0]      active_vec;
    logic [WAYS-1:0]      match_vec;
    logic [WAYS-1:0]      empty_vec;
    logic [WAYS-1:0]      victim_vec;
    logic                 lk_found;
    logic [IDX_W-1:0]     lk_way;

    // Page key on the stored width.
    always_comb
    begin
        key_in = '0;
        key_in[KEY_IN_W-1:0] = page_number[KEY_IN_W-1:0];
    end

    // Active way count, clamped to one and to the way count.
    always_comb
    begin
        cnt_raw = CNT_W'(ways_in_use_reg);
        if (cnt_raw == '0)
        begin
            cnt_eff = CNT_W'(1);
        end
        else if (cnt_raw > WAYS_CNT)
        begin
            cnt_eff = WAYS_CNT;
        end
        else
        begin
            cnt_eff = cnt_raw;
        end
        last_rank = cnt_eff - CNT_W'(1);
    end

    // Parallel compare over the active ways. Ranks of the valid ways are
    // always distinct, so a full set holds exactly one way of the oldest rank.
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            active_vec[w] = (CNT_W'(w) < cnt_eff);
            match_vec[w]  = active_vec[w] && valid_reg[w] && (page_reg[w] == key_in);
            empty_vec[w]  = active_vec[w] && !valid_reg[w];
            victim_vec[w] = active_vec[w] && valid_reg[w] &&
                            (CNT_W'(rank_reg[w]) == last_rank);
        end
        lk_found = |match_vec;
        if (lk_found)
        begin
            lk_way = first_set(match_vec);
        end
        else if (|empty_vec)
        begin
            lk_way = first_set(empty_vec);
        end
        else
        begin
            lk_way = first_set(victim_vec);
        end
    end

    // Lookup register, loaded when a request is accepted.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            key_reg      <= key_in;
            found_reg    <= lk_found;
            way_reg      <= lk_way;
            sel_rank_reg <= rank_reg[lk_way];
        end
    end

    // Page store, written on a fill.
    always_ff @(posedge clk)
    begin
        if (cmd.commit && !found_reg)
        begin
            page_reg[way_reg] <= key_reg;
        end
    end

    // Valid bits and age ranks; a configuration write flushes them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int w = 0; w < WAYS; w++)
            begin
                rank_reg[w] <= '0;
            end
        end
        else if (cfg_write)
        begin
            valid_reg <= '0;
            for (int w = 0; w < WAYS; w++)
            begin
                rank_reg[w] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                if (IDX_W'(w) == way_reg)
                begin
                    valid_reg[w] <= 1'b1;
                    rank_reg[w]  <= '0;
                end
                else if (active_vec[w] && valid_reg[w] && rank_reg[w] != RANK_MAX &&
                         (!found_reg || rank_reg[w] < sel_rank_reg))
                begin
                    rank_reg[w] <= rank_reg[w] + RANK_W'(1);
                end
            end
        end
    end

    // Saturating totals and the reported way.
    always_comb
    begin
        req_next = (req_reg == lrupr_pkg::TOTAL_MAX) ? req_reg :
                   req_reg + lrupr_pkg::TOTAL_W'(1);
        flt_next = (found_reg || flt_reg == lrupr_pkg::TOTAL_MAX) ? flt_reg :
                   flt_reg + lrupr_pkg::TOTAL_W'(1);
        way_used_next = '0;
        way_used_next[OUT_W-1:0] = way_reg[OUT_W-1:0];
    end

    // Configuration register and totals.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ways_in_use_reg <= lrupr_pkg::WAYS_IN_USE_RESET;
            req_reg         <= '0;
            flt_reg         <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                ways_in_use_reg <= ways_in_use;
            end
            if (cmd.commit)
            begin
                req_reg <= req_next;
                flt_reg <= flt_next;
            end
            done_reg <= cmd.commit;
        end
    end

    // Result payload, registered at the update and held until the next update.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            hit_reg      <= found_reg;
            way_used_reg <= way_used_next;
        end
    end

    assign done          = done_reg;
    assign hit           = hit_reg;
    assign way_used      = way_used_reg;
    assign request_total = req_reg;
    assign fault_total   = flt_reg;

    // A miss on a full set finds exactly one oldest way.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture && !lk_found && !(|empty_vec) |-> $onehot(victim_vec))
        else $error("no unique victim on a full set");

    // A page is resident in at most one active way.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> $onehot0(match_vec))
        else $error("page resident in more than one way");

    // Faults never outnumber requests.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (flt_reg <= req_reg))
        else $error("fault total above request total");

    // The way just hit or filled is the most recent one.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && !cfg_write |=> valid_reg[way_reg] && (rank_reg[way_reg] == '0))
        else $error("updated way is not most recent");

endmodule
